>>> hdl/fecw_pkg.sv
// ----------------------------------------------------------------------------
// fecw_pkg - shared types and helpers for the filament edge contact weights
// constants, action codes, result record and saturation helpers
// ----------------------------------------------------------------------------
package fecw_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int COORD_W_DEF   = 32;
  localparam int IDX_W         = 10;
  localparam int CNT_CFG_W     = 11;
  localparam int CNT_W         = 17;   // holds any node count up to 65536
  localparam int OUT_W         = 32;
  localparam int FRAC          = 16;
  localparam int QB            = 34;   // quotient bits kept before saturation
  localparam int SAT_W         = QB + 2;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] weight_start;
    logic signed [OUT_W-1:0] weight_end;
    logic signed [OUT_W-1:0] twist_x;
    logic signed [OUT_W-1:0] twist_y;
    logic signed [OUT_W-1:0] twist_z;
    logic                    degenerate;
    logic                    bad_index;
  } result_t;

  // quotient magnitude and sign to a signed value, overflow pinned high
  function automatic logic signed [SAT_W-1:0] signed_q(input logic neg, input logic ovf,
                                                       input logic [QB-1:0] quo);
    logic [QB-1:0]           mag;
    logic signed [SAT_W-1:0] v;
    mag = ovf ? {QB{1'b1}} : quo;
    v   = $signed({2'b00, mag});
    return neg ? -v : v;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [OUT_W-1:0] res;
    if (v > $signed({{(SAT_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}})) begin
      res = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (v < $signed({{(SAT_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}})) begin
      res = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      res = v[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> hdl/fecw_ram.sv
// ----------------------------------------------------------------------------
// fecw_ram - generic synchronous ram
// one write port, two read ports, registered read data
// ----------------------------------------------------------------------------
module fecw_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> hdl/fecw_sqrt.sv
// ----------------------------------------------------------------------------
// fecw_sqrt - pipelined integer square root
// one root bit per stage, floor result
// ----------------------------------------------------------------------------
module fecw_sqrt #(
  parameter int RW = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] val,
  output logic [RW-1:0]   root
);

  logic [RW+2:0]   rem  [RW+1];
  logic [RW-1:0]   rt   [RW+1];
  logic [2*RW-1:0] rest [RW+1];
  logic [RW+2:0]   tr   [RW];
  logic [RW+2:0]   trial[RW];
  logic            take [RW];

  always_comb begin
    for (int k = 0; k < RW; k++) begin
      tr[k]    = {rem[k][RW:0], rest[k][2*RW-1 -: 2]};
      trial[k] = {1'b0, rt[k], 2'b01};
      take[k]  = tr[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      rt[0]   <= '0;
      rest[0] <= val;
      for (int k = 0; k < RW; k++) begin
        rem[k+1]  <= take[k] ? tr[k] - trial[k] : tr[k];
        rt[k+1]   <= {rt[k][RW-2:0], take[k]};
        rest[k+1] <= rest[k] << 2;
      end
    end
  end

  assign root = rt[RW];

endmodule

>>> hdl/fecw_div.sv
// ----------------------------------------------------------------------------
// fecw_div - pipelined restoring divider
// unsigned, keeps QB quotient bits and flags a larger quotient
// ----------------------------------------------------------------------------
module fecw_div #(
  parameter int NW   = 82,
  parameter int DENW = 66
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [NW-1:0]           num,
  input  logic [DENW-1:0]         den,
  output logic [fecw_pkg::QB-1:0] quo,
  output logic                    ovf
);

  localparam int Q   = fecw_pkg::QB;
  localparam int NX  = (NW > Q) ? NW : Q + 1;
  localparam int HW  = NX - Q;
  localparam int CMW = (HW > DENW) ? HW : DENW;
  localparam int RMW = DENW + 1;

  logic [NX-1:0]   num_x;
  logic [HW-1:0]   hi;
  logic [RMW-1:0]  rem  [Q+1];
  logic [Q-1:0]    qt   [Q+1];
  logic [Q-1:0]    lo   [Q+1];
  logic [DENW-1:0] dn   [Q+1];
  logic            ov   [Q+1];
  logic [RMW-1:0]  tr   [Q];
  logic            take [Q];

  assign num_x = NX'(num);
  assign hi    = num_x[NX-1:Q];

  always_comb begin
    for (int i = 0; i < Q; i++) begin
      tr[i]   = {rem[i][DENW-1:0], lo[i][Q-1]};
      take[i] = tr[i] >= {1'b0, dn[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // quotient beyond Q bits when the top part already reaches the divisor
      ov[0]  <= CMW'(hi) >= CMW'(den);
      rem[0] <= RMW'(hi);
      qt[0]  <= '0;
      lo[0]  <= num_x[Q-1:0];
      dn[0]  <= den;
      for (int i = 0; i < Q; i++) begin
        rem[i+1] <= take[i] ? tr[i] - {1'b0, dn[i]} : tr[i];
        qt[i+1]  <= {qt[i][Q-2:0], take[i]};
        lo[i+1]  <= lo[i] << 1;
        dn[i+1]  <= dn[i];
        ov[i+1]  <= ov[i];
      end
    end
  end

  assign quo = qt[Q];
  assign ovf = ov[Q];

endmodule

>>> hdl/filament_edge_contact_weights_core.sv
// ----------------------------------------------------------------------------
// filament_edge_contact_weights_core - contact weights on a filament edge
// throughput one item per cycle while the skid stage is empty, set by the
// fully pipelined sqrt and dividers
// node writes give no result; the node store has no clear
// sync reset empties pipeline, output and skid stages, sets node count to 2
// ----------------------------------------------------------------------------
module filament_edge_contact_weights_core #(
  parameter int MAX_NODES   = fecw_pkg::MAX_NODES_DEF,
  parameter int COORD_WIDTH = fecw_pkg::COORD_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // item input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [fecw_pkg::IDX_W-1:0]        index,
  input  logic signed [COORD_WIDTH-1:0]     coord_x,
  input  logic signed [COORD_WIDTH-1:0]     coord_y,
  input  logic signed [COORD_WIDTH-1:0]     coord_z,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fecw_pkg::OUT_W-1:0] weight_start,
  output logic signed [fecw_pkg::OUT_W-1:0] weight_end,
  output logic signed [fecw_pkg::OUT_W-1:0] twist_x,
  output logic signed [fecw_pkg::OUT_W-1:0] twist_y,
  output logic signed [fecw_pkg::OUT_W-1:0] twist_z,
  output logic                              degenerate,
  output logic                              bad_index,
  // configuration write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fecw_pkg::CNT_CFG_W-1:0]    node_count
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;          // coordinate differences
  localparam int SW  = 2 * DW;          // products and squared length
  localparam int RW  = DW;              // edge length (root of SW bits)
  localparam int AW  = $clog2(MAX_NODES);
  localparam int Q   = fecw_pkg::QB;
  localparam int NW2 = SW + fecw_pkg::FRAC;
  localparam int NST = 5 + RW + 1 + Q + 1;
  localparam int PW  = 6 + 5 * SW;      // payload carried alongside the sqrt
  localparam int FW  = 6;               // flags carried alongside the dividers

  // ---------------------------------------------------------------------------
  // configuration: single register, always ready
  // ---------------------------------------------------------------------------
  logic [fecw_pkg::CNT_CFG_W-1:0] count_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= fecw_pkg::CNT_CFG_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      count_reg <= node_count;
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline advance: the whole pipe moves unless the skid stage is occupied,
  // so an item can always leave the last stage into the output or skid register
  // ---------------------------------------------------------------------------
  logic               adv;
  logic               skid_v;
  logic               acc;
  logic [NST-1:0]     vld;

  assign adv      = !skid_v;
  assign in_stall = skid_v;
  assign acc      = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // accept: edge index check, successor wrap, store access
  // ---------------------------------------------------------------------------
  logic [fecw_pkg::CNT_W-1:0] idx_w;
  logic [fecw_pkg::CNT_W-1:0] cnt_w;
  logic [fecw_pkg::CNT_W-1:0] succ_inc;
  logic [fecw_pkg::CNT_W-1:0] succ_w;
  logic                       idx_bad;
  logic                       is_query;
  logic                       st_we;
  logic [3*CW-1:0]            node_a;
  logic [3*CW-1:0]            node_b;

  assign is_query = (action == fecw_pkg::ACT_QUERY);
  assign idx_w    = fecw_pkg::CNT_W'(index);
  // counts above the store depth clamp to the depth
  assign cnt_w    = (fecw_pkg::CNT_W'(count_reg) > fecw_pkg::CNT_W'(MAX_NODES)) ?
                    fecw_pkg::CNT_W'(MAX_NODES) : fecw_pkg::CNT_W'(count_reg);
  assign idx_bad  = idx_w >= cnt_w;
  assign succ_inc = idx_w + fecw_pkg::CNT_W'(1);
  // last node in use wraps to node zero
  assign succ_w   = (succ_inc >= cnt_w) ? '0 : succ_inc;
  // writes beyond the store are dropped
  assign st_we    = acc && (action == fecw_pkg::ACT_WRITE) &&
                    (idx_w < fecw_pkg::CNT_W'(MAX_NODES));

  // a write lands at its transfer edge and a later query reads at its own
  // transfer edge, so a query always sees every earlier write without bypass
  fecw_ram #(
    .WIDTH (3 * CW),
    .DEPTH (MAX_NODES)
  ) u_node_store (
    .clk     (clk),
    .we      (st_we),
    .waddr   (idx_w[AW-1:0]),
    .wdata   ({coord_z, coord_y, coord_x}),
    .re      (adv),
    .raddr_a (idx_w[AW-1:0]),
    .raddr_b (succ_w[AW-1:0]),
    .rdata_a (node_a),
    .rdata_b (node_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], acc && is_query};
    end
  end

  // stage 1: contact point held beside the store read
  logic [3*CW-1:0] s1_p;
  logic            s1_bad;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p   <= {coord_z, coord_y, coord_x};
      s1_bad <= idx_bad;
    end
  end

  // stage 2: edge vector d and offset r
  logic signed [DW-1:0] d [3];
  logic signed [DW-1:0] r [3];
  logic                 s2_bad;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        d[k] <= $signed({node_b[k*CW+CW-1], node_b[k*CW +: CW]}) -
                $signed({node_a[k*CW+CW-1], node_a[k*CW +: CW]});
        r[k] <= $signed({s1_p[k*CW+CW-1], s1_p[k*CW +: CW]}) -
                $signed({node_a[k*CW+CW-1], node_a[k*CW +: CW]});
      end
      s2_bad <= s1_bad;
    end
  end

  // stage 3: all products, one multiplier level
  logic signed [SW-1:0] pdd [3];
  logic signed [SW-1:0] prd [3];
  logic signed [SW-1:0] pc  [6];
  logic                 s3_bad;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pdd[k] <= SW'(d[k]) * SW'(d[k]);
        prd[k] <= SW'(r[k]) * SW'(d[k]);
      end
      pc[0]  <= SW'(d[1]) * SW'(r[2]);
      pc[1]  <= SW'(d[2]) * SW'(r[1]);
      pc[2]  <= SW'(d[2]) * SW'(r[0]);
      pc[3]  <= SW'(d[0]) * SW'(r[2]);
      pc[4]  <= SW'(d[0]) * SW'(r[1]);
      pc[5]  <= SW'(d[1]) * SW'(r[0]);
      s3_bad <= s2_bad;
    end
  end

  // stage 4: squared length, dot product, cross product
  logic [SW-1:0]        s4_s;
  logic signed [SW:0]   s4_dot;
  logic signed [SW-1:0] s4_c [3];
  logic                 s4_bad;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_s   <= pdd[0] + pdd[1] + pdd[2];
      s4_dot <= {prd[0][SW-1], prd[0]} + {prd[1][SW-1], prd[1]} + {prd[2][SW-1], prd[2]};
      for (int k = 0; k < 3; k++) begin
        s4_c[k] <= pc[2*k] - pc[2*k+1];
      end
      s4_bad <= s3_bad;
    end
  end

  // stage 5: sign and magnitude for the dividers
  logic [SW:0]   dot_neg_v;
  logic [SW-1:0] c_neg_v [3];
  logic [SW-1:0] s5_s;
  logic [SW-1:0] s5_dmag;
  logic [SW-1:0] s5_cmag [3];
  logic          s5_dneg;
  logic [2:0]    s5_cneg;
  logic          s5_degen;
  logic          s5_bad;

  always_comb begin
    dot_neg_v = -s4_dot;
    for (int k = 0; k < 3; k++) begin
      c_neg_v[k] = -s4_c[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_s     <= s4_s;
      s5_dneg  <= s4_dot[SW];
      s5_dmag  <= s4_dot[SW] ? dot_neg_v[SW-1:0] : s4_dot[SW-1:0];
      for (int k = 0; k < 3; k++) begin
        s5_cneg[k] <= s4_c[k][SW-1];
        s5_cmag[k] <= s4_c[k][SW-1] ? c_neg_v[k] : s4_c[k];
      end
      s5_degen <= (s4_s == '0);
      s5_bad   <= s4_bad;
    end
  end

  // ---------------------------------------------------------------------------
  // edge length, with the rest of the item held in a delay line beside it
  // ---------------------------------------------------------------------------
  logic [RW-1:0] len;
  logic [PW-1:0] pdl [RW+1];

  fecw_sqrt #(
    .RW (RW)
  ) u_sqrt (
    .clk  (clk),
    .en   (adv),
    .val  (s5_s),
    .root (len)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      pdl[0] <= {s5_bad, s5_degen, s5_dneg, s5_cneg, s5_dmag, s5_s,
                 s5_cmag[2], s5_cmag[1], s5_cmag[0]};
      for (int i = 1; i <= RW; i++) begin
        pdl[i] <= pdl[i-1];
      end
    end
  end

  logic [SW-1:0] q_dmag;
  logic [SW-1:0] q_s;
  logic [SW-1:0] q_cmag [3];
  logic [FW-1:0] q_flags;

  assign q_flags   = pdl[RW][PW-1 -: FW];
  assign q_dmag    = pdl[RW][5*SW-1 -: SW];
  assign q_s       = pdl[RW][4*SW-1 -: SW];
  assign q_cmag[2] = pdl[RW][3*SW-1 -: SW];
  assign q_cmag[1] = pdl[RW][2*SW-1 -: SW];
  assign q_cmag[0] = pdl[RW][SW-1:0];

  // ---------------------------------------------------------------------------
  // dividers: projection over squared length, cross product over length
  // ---------------------------------------------------------------------------
  logic [Q-1:0]  w2_quo;
  logic          w2_ovf;
  logic [Q-1:0]  tw_quo [3];
  logic          tw_ovf [3];
  logic [FW-1:0] fdl [Q+1];

  fecw_div #(
    .NW   (NW2),
    .DENW (SW)
  ) u_div_w2 (
    .clk (clk),
    .en  (adv),
    .num ({q_dmag, {fecw_pkg::FRAC{1'b0}}}),
    .den (q_s),
    .quo (w2_quo),
    .ovf (w2_ovf)
  );

  for (genvar k = 0; k < 3; k++) begin : g_twist
    fecw_div #(
      .NW   (SW),
      .DENW (RW)
    ) u_div_tw (
      .clk (clk),
      .en  (adv),
      .num (q_cmag[k]),
      .den (len),
      .quo (tw_quo[k]),
      .ovf (tw_ovf[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fdl[0] <= q_flags;
      for (int i = 1; i <= Q; i++) begin
        fdl[i] <= fdl[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result: signs back on, one minus projection, saturate, zero on flags
  // flag order: bad, degenerate, dot sign, cross signs z y x
  // ---------------------------------------------------------------------------
  logic                           f_bad;
  logic                           f_degen;
  logic signed [fecw_pkg::SAT_W-1:0] w2_s;
  logic signed [fecw_pkg::SAT_W-1:0] w0_s;
  fecw_pkg::result_t              fin;
  logic                           fin_v;

  assign f_bad   = fdl[Q][5];
  assign f_degen = fdl[Q][4];
  assign fin_v   = adv && vld[NST-1];
  assign w2_s    = fecw_pkg::signed_q(fdl[Q][3], w2_ovf, w2_quo);
  assign w0_s    = $signed(fecw_pkg::SAT_W'(1) << fecw_pkg::FRAC) - w2_s;

  always_comb begin
    fin = '0;
    fin.bad_index  = f_bad;
    fin.degenerate = !f_bad && f_degen;
    if (!f_bad && !f_degen) begin
      fin.weight_start = fecw_pkg::sat32(w0_s);
      fin.weight_end   = fecw_pkg::sat32(w2_s);
      fin.twist_x      = fecw_pkg::sat32(fecw_pkg::signed_q(fdl[Q][0], tw_ovf[0], tw_quo[0]));
      fin.twist_y      = fecw_pkg::sat32(fecw_pkg::signed_q(fdl[Q][1], tw_ovf[1], tw_quo[1]));
      fin.twist_z      = fecw_pkg::sat32(fecw_pkg::signed_q(fdl[Q][2], tw_ovf[2], tw_quo[2]));
    end
  end

  // ---------------------------------------------------------------------------
  // output register plus skid register: a stalled result parks the next one
  // in the skid stage, and only a full skid stage holds the pipeline
  // ---------------------------------------------------------------------------
  logic              out_v;
  fecw_pkg::result_t out_r;
  fecw_pkg::result_t skid_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      priority if (out_v && out_stall) begin
        if (fin_v) begin
          skid_v <= 1'b1;
        end
      end else if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= fin_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (out_v && out_stall) begin
      if (fin_v) begin
        skid_r <= fin;
      end
    end else if (skid_v) begin
      out_r <= skid_r;
    end else begin
      out_r <= fin;
    end
  end

  assign out_valid    = out_v;
  assign weight_start = out_r.weight_start;
  assign weight_end   = out_r.weight_end;
  assign twist_x      = out_r.twist_x;
  assign twist_y      = out_r.twist_y;
  assign twist_z      = out_r.twist_z;
  assign degenerate   = out_r.degenerate;
  assign bad_index    = out_r.bad_index;

endmodule

>>> hdl/fecw_check.sv
// ----------------------------------------------------------------------------
// fecw_check - port level checks for the contact weights core
// reset, flag exclusivity, zeroed results, stall origin and held results
// ----------------------------------------------------------------------------
module fecw_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [fecw_pkg::OUT_W-1:0] weight_start,
  input logic signed [fecw_pkg::OUT_W-1:0] weight_end,
  input logic signed [fecw_pkg::OUT_W-1:0] twist_x,
  input logic signed [fecw_pkg::OUT_W-1:0] twist_y,
  input logic signed [fecw_pkg::OUT_W-1:0] twist_z,
  input logic                              degenerate,
  input logic                              bad_index
);

  // reset empties the output and skid stages
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(degenerate && bad_index))
    else $error("degenerate and bad_index together");

  // flagged results carry zero weights and twist
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (degenerate || bad_index) |->
      weight_start == '0 && weight_end == '0 && twist_x == '0 &&
      twist_y == '0 && twist_z == '0)
    else $error("flagged result not zero");

  // input stall only starts behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(weight_end) && $stable(bad_index))
    else $error("stalled result changed");

endmodule

bind filament_edge_contact_weights_core fecw_check u_fecw_check (.*);
